/* design/spq_pkg.sv */
package spq_pkg;

   localparam int QUEUE_CAPACITY   = 16;
   localparam int KEY_W            = 32;
   localparam int PAYLOAD_W        = 32;
   localparam int OPCODE_W         = 2;
   localparam int COUNT_W          = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_NOP    = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

/* design/spq_req_if.sv */
interface spq_req_if;
   logic                           valid;
   logic                           ready;
   logic [spq_pkg::OPCODE_W-1:0]   opcode;
   logic [spq_pkg::KEY_W-1:0]      entry_key;
   logic [spq_pkg::PAYLOAD_W-1:0]  entry_payload;

   modport source (output valid, output opcode, output entry_key, output entry_payload,
                   input ready);
   modport sink   (input valid, input opcode, input entry_key, input entry_payload,
                   output ready);
endinterface

/* design/spq_rsp_if.sv */
interface spq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [spq_pkg::COUNT_W-1:0]    entry_count;
   logic                           head_valid;
   logic [spq_pkg::KEY_W-1:0]      head_key;
   logic [spq_pkg::PAYLOAD_W-1:0]  head_payload;

   modport source (output valid, output accepted, output entry_count, output head_valid,
                   output head_key, output head_payload, input ready);
   modport sink   (input valid, input accepted, input entry_count, input head_valid,
                   input head_key, input head_payload, output ready);
endinterface

/* design/spq_cell.sv */
module spq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type     new_entry,
   input  spq_pkg::entry_type     left_entry,
   input  logic                   left_greater,
   input  spq_pkg::entry_type     right_entry,
   input  logic [CNT_W-1:0]       count,
   output spq_pkg::entry_type     entry,
   output logic                   greater
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               occupied;

   assign occupied = count > CNT_W'(INDEX);
   assign greater  = occupied && (entry_ff.key > new_entry.key);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         // stay put, take the new entry, or shift back from the left
         priority if (greater) begin
            entry_in = entry_ff;
         end else if (left_greater) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* design/sorted_priority_queue.sv */
// sorted priority queue, kept as a chain of cells ordered front first
//
// req_ch carries one operation per beat: insert (key, payload), remove the
// front entry, or no-op. rsp_ch returns exactly one status beat per request:
// accepted flag, entry count after the operation, and the front entry with
// its valid flag (key and payload read zero when empty).
// an insert into a full queue or a remove from an empty one is refused and
// leaves the contents unchanged.
//
// the status beat is registered and valid in the cycle after the request beat.
// throughput: one operation per cycle while rsp_ch keeps up; every cell
// compares against the new key and shifts toward its neighbor in the same
// cycle, so the cell chain sets the rate, not the depth.
// when rsp_ch stalls, the pending status beat is held and req_ch.ready drops
// until it is taken; the beat leaves and the next request enters together.
// reset (synchronous, active high) empties the queue and drops rsp valid;
// entry storage itself is not cleared, only the count is.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::QUEUE_CAPACITY
) (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // queue control
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   accepted_ff;
   logic                   fire;
   logic                   full;
   logic                   empty;
   logic                   op_ok;
   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::entry_type     new_entry;

   // cell chain taps
   spq_pkg::entry_type cell_entry   [CAPACITY];
   logic               cell_greater [CAPACITY];

   assign fire         = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign full         = count_ff == CNT_W'(CAPACITY);
   assign empty        = count_ff == '0;

   assign new_entry.key     = req_ch.entry_key;
   assign new_entry.payload = req_ch.entry_payload;

   // decode the operation; unused opcode behaves as a no-op
   always_comb begin
      ctrl  = '0;
      op_ok = 1'b1;
      unique case (spq_pkg::opcode_type'(req_ch.opcode))
         spq_pkg::OP_INSERT: begin
            op_ok       = !full;
            ctrl.insert = fire && !full;
         end
         spq_pkg::OP_REMOVE: begin
            op_ok       = !empty;
            ctrl.remove = fire && !empty;
         end
         default: begin
            op_ok = 1'b1;
         end
      endcase
   end

   always_comb begin
      priority if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         accepted_ff <= op_ok;
      end
   end

   // cell chain: front at index 0, each cell sees its two neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_greater;

      if (i == 0) begin : g_front
         assign left_entry   = new_entry;
         assign left_greater = 1'b1;
      end else begin : g_mid
         assign left_entry   = cell_entry[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_entry    (new_entry),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .count        (count_ff),
         .entry        (cell_entry[i]),
         .greater      (cell_greater[i])
      );
   end

   // status comes straight from the registered count and front cell; neither
   // changes while a beat waits, since no request enters until it is taken
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = accepted_ff;
   assign rsp_ch.entry_count  = spq_pkg::COUNT_W'(count_ff);
   assign rsp_ch.head_valid   = !empty;
   assign rsp_ch.head_key     = empty ? '0 : cell_entry[0].key;
   assign rsp_ch.head_payload = empty ? '0 : cell_entry[0].payload;

   // count never runs past the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // a done insert grows the queue by exactly one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance count");

   // no-op and refused operations leave the count alone
   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      (fire && !ctrl.insert && !ctrl.remove) |=> $stable(count_ff))
      else $error("count moved without an operation");

   // front two entries stay in non-increasing key order
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> cell_entry[0].key >= cell_entry[1].key)
      else $error("front entries out of order");

endmodule
